### sv/clock_menu_mode_controller_unit_assert.svh
// Assertion macros used by the clock menu mode controller RTL.
`ifndef CLOCK_MENU_MODE_CONTROLLER_UNIT_ASSERT_SVH
`define CLOCK_MENU_MODE_CONTROLLER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define CMMC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("clock menu assertion failed");
// Check a property on every clock edge, reset included.
`define CMMC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("clock menu assertion failed");
`else
`define CMMC_ASSERT(label, prop)
`define CMMC_ASSERT_ALWAYS(label, prop)
`endif
`endif

### sv/cmmc_pkg.sv
// Types, codes and arithmetic helpers of the clock menu mode controller.
package cmmc_pkg;

  // Display modes
  localparam logic [1:0] MODE_TIME = 2'd0;
  localparam logic [1:0] MODE_TEMP = 2'd1;
  localparam logic [1:0] MODE_SET_HOUR = 2'd2;
  localparam logic [1:0] MODE_SET_MIN = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_LONG_PRESS = 3'd0;
  localparam logic [2:0] CFG_TICKS_SLOW = 3'd1;
  localparam logic [2:0] CFG_TICKS_FAST = 3'd2;
  localparam logic [2:0] CFG_AUTO_COLOR = 3'd3;
  localparam logic [2:0] CFG_MIN_BRIGHT = 3'd4;
  localparam logic [2:0] CFG_MAX_BRIGHT = 3'd5;

  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned CfgDataWidth = 16;

  // Reset values
  localparam logic [15:0] LONG_PRESS_RST = 16'd500;
  localparam logic [7:0] TICKS_SLOW_RST = 8'd5;
  localparam logic [7:0] TICKS_FAST_RST = 8'd25;
  localparam logic [7:0] MIN_BRIGHT_RST = 8'd1;
  localparam logic [7:0] MAX_BRIGHT_RST = 8'd40;
  localparam logic [15:0] HUE_RST = 16'd2184;
  localparam logic [7:0] BRIGHT_RST = 8'd1;

  // Range limits
  localparam logic [4:0] HOUR_LAST = 5'd23;
  localparam logic [5:0] MINUTE_LAST = 6'd59;
  localparam logic [6:0] TEMP_LAST = 7'd99;
  localparam logic [5:0] HOUR_ADVANCE_MIN = 6'd39;

  typedef struct packed {
    logic        mode;
    logic        button_down;
    logic [31:0] time_ms;
    logic [4:0]  clock_hour;
    logic [5:0]  clock_minute;
    logic [6:0]  temp_celsius;
    logic [9:0]  light_level;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  display_mode;
    logic [3:0]  hour_word;
    logic [3:0]  minute_word;
    logic [2:0]  dot_count;
    logic [3:0]  digit_tens;
    logic [3:0]  digit_ones;
    logic [7:0]  bright_level;
    logic [15:0] hue_value;
    logic        clock_write;
    logic [4:0]  write_hour;
    logic [5:0]  write_minute;
  } out_beat_t;

  // Held input beat; light is already reduced to the brightness product
  typedef struct packed {
    logic               mode;
    logic               button_down;
    logic [31:0]        time_ms;
    logic [4:0]         clock_hour;
    logic [5:0]         clock_minute;
    logic [6:0]         temp_celsius;
    logic signed [15:0] bright_prod;
  } staged_t;

  // Divide a value below 1029 by ten through the reciprocal 205/2048
  function automatic logic [6:0] div10(input logic [9:0] x);
    logic [17:0] p;
    p = 18'(x) * 18'd205;
    return p[17:11];
  endfunction

  // Divide a minute (0..63) by five through the reciprocal 205/1024
  function automatic logic [3:0] div5(input logic [5:0] x);
    logic [13:0] p;
    p = 14'(x) * 14'd205;
    return p[13:10];
  endfunction

endpackage

### sv/clock_menu_mode_controller_unit.sv
// Clock menu mode controller: button timing, menu modes, word indices and brightness.
// A beat is held in the input register; when it advances, the result of a tick beat
// is loaded into the output register, and a button beat gives no result beat.
// Throughput: one beat per cycle unless a tick beat waits on a stalled full output;
// the state update is one pass of logic between the input and output registers.
// Reset: rst_ni clears all control and menu state and loads the register defaults.
module clock_menu_mode_controller_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  cmmc_pkg::in_beat_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output cmmc_pkg::out_beat_t   out_data_o,
  input  logic                  cfg_we_i,
  input  logic [cmmc_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [cmmc_pkg::CfgDataWidth-1:0] cfg_wdata_i
);
  import cmmc_pkg::*;

  // Configuration registers
  logic [15:0] long_press_q;
  logic [7:0]  ticks_slow_q, ticks_fast_q, min_bright_q, max_bright_q;
  logic        auto_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q <= LONG_PRESS_RST;
      ticks_slow_q <= TICKS_SLOW_RST;
      ticks_fast_q <= TICKS_FAST_RST;
      auto_color_q <= 1'b1;
      min_bright_q <= MIN_BRIGHT_RST;
      max_bright_q <= MAX_BRIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LONG_PRESS: long_press_q <= cfg_wdata_i;
        CFG_TICKS_SLOW: ticks_slow_q <= cfg_wdata_i[7:0];
        CFG_TICKS_FAST: ticks_fast_q <= cfg_wdata_i[7:0];
        CFG_AUTO_COLOR: auto_color_q <= cfg_wdata_i[0];
        CFG_MIN_BRIGHT: min_bright_q <= cfg_wdata_i[7:0];
        CFG_MAX_BRIGHT: max_bright_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Handshake: a held beat advances when it needs no result slot or one is free
  logic    in_valid_q, out_valid_q, advance, accept, out_free;
  staged_t in_q;
  out_beat_t out_q, out_d;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && (in_q.mode || out_free);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  // Reduce the light sample to pct * (max - min) on the way in
  logic [6:0]         light_pct;
  logic signed [8:0]  bright_diff;
  logic signed [16:0] prod_full;

  always_comb begin
    light_pct   = div10(in_data_i.light_level);
    bright_diff = $signed({1'b0, max_bright_q}) - $signed({1'b0, min_bright_q});
    prod_full   = 17'($signed({1'b0, light_pct}) * bright_diff);
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q.mode         <= in_data_i.mode;
      in_q.button_down  <= in_data_i.button_down;
      in_q.time_ms      <= in_data_i.time_ms;
      in_q.clock_hour   <= in_data_i.clock_hour;
      in_q.clock_minute <= in_data_i.clock_minute;
      in_q.temp_celsius <= in_data_i.temp_celsius;
      in_q.bright_prod  <= prod_full[15:0];
    end
  end

  // Menu state
  logic [1:0]  menu_state_q, menu_state_d;
  logic [7:0]  menu_count_q, menu_count_d;
  logic [4:0]  edit_hour_q, edit_hour_d;
  logic [5:0]  edit_minute_q, edit_minute_d;
  logic        pending_q, pending_d;
  logic [31:0] stamp_q, stamp_d;
  logic [3:0]  shown_hour_q, shown_hour_d;
  logic [3:0]  shown_word_q, shown_word_d;
  logic [2:0]  shown_dots_q, shown_dots_d;
  logic [15:0] hue_q, hue_d;
  logic [7:0]  bright_q, bright_d;

  // Clamped inputs and derived time-mode values
  logic [4:0]  hour24;
  logic [5:0]  minute;
  logic [6:0]  temp;
  logic [3:0]  h12, hword;
  logic [3:0]  min_word;
  logic [31:0] press_len;
  logic [15:0] hue_auto;

  // Brightness: floor(prod / 100) + min, saturated
  logic        prod_neg;
  logic [14:0] prod_mag, prod_adj;
  logic [27:0] quot_full;
  logic [8:0]  quot_mag;
  logic signed [10:0] bright_sum;
  logic [7:0]  bright_new;

  // Digit split
  logic [6:0] digit_val, tens_full;
  logic [3:0] tens, ones;
  logic       wr;

  always_comb begin
    hour24    = (in_q.clock_hour > HOUR_LAST) ? in_q.clock_hour - 5'd24 : in_q.clock_hour;
    minute    = (in_q.clock_minute > MINUTE_LAST) ? MINUTE_LAST : in_q.clock_minute;
    temp      = (in_q.temp_celsius > TEMP_LAST) ? TEMP_LAST : in_q.temp_celsius;
    h12       = (hour24 > 5'd12) ? 4'(hour24 - 5'd12) : hour24[3:0];
    hword     = h12;
    if (minute > HOUR_ADVANCE_MIN) begin
      hword = (h12 == 4'd12) ? 4'd1 : h12 + 4'd1;
    end
    if (hword == 4'd0) begin
      hword = 4'd12;
    end
    min_word  = div5(minute);
    hue_auto  = {minute, 9'd0} + {1'b0, minute, 8'd0} + {4'd0, minute, 5'd0};
    press_len = in_q.time_ms - stamp_q;

    prod_neg   = in_q.bright_prod[15];
    prod_mag   = prod_neg ? 15'(-in_q.bright_prod) : in_q.bright_prod[14:0];
    prod_adj   = prod_neg ? prod_mag + 15'd99 : prod_mag;
    quot_full  = 28'(prod_adj) * 28'd5243;
    quot_mag   = quot_full[27:19];
    bright_sum = prod_neg ? -$signed({2'b0, quot_mag}) : $signed({2'b0, quot_mag});
    bright_sum = bright_sum + $signed({3'b0, min_bright_q});
    if (bright_sum < 0) begin
      bright_new = 8'd0;
    end else if (bright_sum > 11'sd255) begin
      bright_new = 8'd255;
    end else begin
      bright_new = bright_sum[7:0];
    end
  end

  // State update for one beat
  always_comb begin
    menu_state_d  = menu_state_q;
    menu_count_d  = menu_count_q;
    edit_hour_d   = edit_hour_q;
    edit_minute_d = edit_minute_q;
    pending_d     = pending_q;
    stamp_d       = stamp_q;
    shown_hour_d  = shown_hour_q;
    shown_word_d  = shown_word_q;
    shown_dots_d  = shown_dots_q;
    hue_d         = hue_q;
    bright_d      = bright_q;
    wr            = 1'b0;

    if (in_q.mode) begin
      // Button edge: stamp on press, classify on release
      if (in_q.button_down) begin
        stamp_d = in_q.time_ms;
      end else if (press_len > {16'd0, long_press_q}) begin
        if (menu_state_q == MODE_TIME) begin
          menu_state_d = MODE_SET_HOUR;
          menu_count_d = 8'd0;
        end
      end else if (menu_state_q == MODE_TIME || menu_state_q == MODE_TEMP) begin
        menu_state_d = MODE_TEMP;
        menu_count_d = 8'd0;
      end else begin
        pending_d = 1'b1;
      end
    end else begin
      case (menu_state_q)
        MODE_TIME: begin
          bright_d     = bright_new;
          edit_hour_d  = {1'b0, h12};
          shown_hour_d = hword;
          shown_word_d = min_word;
          shown_dots_d = 3'(minute - 6'({min_word, 2'b00} + {2'b00, min_word}));
          if (auto_color_q) begin
            hue_d = hue_auto;
          end
        end
        MODE_TEMP: begin
          menu_count_d = menu_count_q + 8'd1;
          if (menu_count_d == ticks_slow_q) begin
            menu_state_d = MODE_TIME;
          end
        end
        MODE_SET_HOUR: begin
          if (pending_q) begin
            pending_d    = 1'b0;
            edit_hour_d  = (edit_hour_q < HOUR_LAST) ? edit_hour_q + 5'd1 : 5'd0;
            menu_count_d = 8'd0;
          end
          menu_count_d = menu_count_d + 8'd1;
          if (menu_count_d == ticks_fast_q) begin
            menu_state_d  = MODE_SET_MIN;
            menu_count_d  = 8'd0;
            edit_minute_d = minute;
          end
        end
        default: begin
          if (pending_q) begin
            pending_d     = 1'b0;
            edit_minute_d = (edit_minute_q < MINUTE_LAST) ? edit_minute_q + 6'd1 : 6'd0;
            menu_count_d  = 8'd0;
          end
          menu_count_d = menu_count_d + 8'd1;
          if (menu_count_d == ticks_fast_q) begin
            wr           = 1'b1;
            menu_state_d = MODE_TIME;
          end
        end
      endcase
    end

    // Pick the two-digit value for the new mode
    case (menu_state_d)
      MODE_TEMP:     digit_val = temp;
      MODE_SET_HOUR: digit_val = {2'b0, edit_hour_d};
      MODE_SET_MIN:  digit_val = {1'b0, edit_minute_d};
      default:       digit_val = 7'd0;
    endcase
    tens_full = div10({3'b0, digit_val});
    tens      = tens_full[3:0];
    ones      = 4'(digit_val - 7'({tens_full[3:0], 3'b000} + {2'b00, tens_full[3:0], 1'b0}));

    out_d.display_mode = menu_state_d;
    out_d.hour_word    = shown_hour_d;
    out_d.minute_word  = shown_word_d;
    out_d.dot_count    = shown_dots_d;
    out_d.digit_tens   = tens;
    out_d.digit_ones   = ones;
    out_d.bright_level = bright_d;
    out_d.hue_value    = hue_d;
    out_d.clock_write  = wr;
    out_d.write_hour   = wr ? edit_hour_d : 5'd0;
    out_d.write_minute = wr ? edit_minute_d : 6'd0;
  end

  // Commit state when the held beat advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      menu_state_q  <= MODE_TIME;
      menu_count_q  <= 8'd0;
      edit_hour_q   <= 5'd0;
      edit_minute_q <= 6'd0;
      pending_q     <= 1'b0;
      stamp_q       <= 32'd0;
      shown_hour_q  <= 4'd0;
      shown_word_q  <= 4'd0;
      shown_dots_q  <= 3'd0;
      hue_q         <= HUE_RST;
      bright_q      <= BRIGHT_RST;
    end else if (advance) begin
      menu_state_q  <= menu_state_d;
      menu_count_q  <= menu_count_d;
      edit_hour_q   <= edit_hour_d;
      edit_minute_q <= edit_minute_d;
      pending_q     <= pending_d;
      stamp_q       <= stamp_d;
      shown_hour_q  <= shown_hour_d;
      shown_word_q  <= shown_word_d;
      shown_dots_q  <= shown_dots_d;
      hue_q         <= hue_d;
      bright_q      <= bright_d;
    end
  end

  // Output register: load on a tick beat, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && !in_q.mode) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && !in_q.mode) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `include "clock_menu_mode_controller_unit_assert.svh"

  `CMMC_ASSERT(a_write_returns_to_time,
      out_valid_q && out_q.clock_write |-> out_q.display_mode == MODE_TIME)
  `CMMC_ASSERT(a_time_mode_no_digits,
      out_valid_q && out_q.display_mode == MODE_TIME |->
      out_q.digit_tens == 4'd0 && out_q.digit_ones == 4'd0)
  `CMMC_ASSERT(a_digits_decimal,
      out_valid_q |-> out_q.digit_tens <= 4'd9 && out_q.digit_ones <= 4'd9)
  `CMMC_ASSERT_ALWAYS(a_pending_only_in_edit,
      pending_q |-> menu_state_q == MODE_SET_HOUR || menu_state_q == MODE_SET_MIN)
  `CMMC_ASSERT(a_stall_needs_held_beat, in_stall_o |-> in_valid_q && !in_q.mode)

endmodule

### bench/clock_menu_mode_controller_unit_tb.sv
// Self-checking testbench for the clock menu mode controller unit.
`timescale 1ns / 1ps

module clock_menu_mode_controller_unit_tb;
  import cmmc_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ItemsPerPhase = 155;
  localparam int unsigned NumPhases = 8;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned HoldOffCycles = 300;
  localparam logic [15:0] HueStep = 16'd800;

  // Beat kinds and button levels
  localparam logic EV_TICK = 1'b0;
  localparam logic EV_BUTTON = 1'b1;
  localparam logic KEY_RELEASE = 1'b0;
  localparam logic KEY_PRESS = 1'b1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_idx = '0;
  logic [CfgDataWidth-1:0] cfg_wdata = '0;

  clock_menu_mode_controller_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Beats waiting to be sent and results still owed by the block
  in_beat_t  beat_q[$];
  out_beat_t expected_q[$];

  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned pushed = 0;
  int unsigned accepted = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_left = 0;
  bit beat_taken = 1'b0;
  logic [31:0] clock_ms;

  // Register copies
  logic [15:0] cfg_long;
  logic [7:0]  cfg_slow, cfg_fast, cfg_min, cfg_max;
  logic        cfg_auto;

  // Controller state
  logic [1:0]  mode_r;
  logic [7:0]  menu_cnt;
  logic [4:0]  edit_hr;
  logic [5:0]  edit_mn;
  logic        press_wait;
  logic [31:0] press_ms;
  logic [3:0]  word_hour, word_min;
  logic [2:0]  word_dots;
  logic [15:0] hue_r;
  logic [7:0]  bright_r;

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Brightness: floor(pct * (max - min) / 100) + min, pct = light / 10, clamped to a byte
  function automatic logic [7:0] bright_of(input logic [9:0] light);
    int pct, prod, q;
    pct = int'(light) / 10;
    prod = pct * (int'(cfg_max) - int'(cfg_min));
    q = prod / 100;
    if (prod < 0 && q * 100 != prod) q = q - 1;
    q = q + int'(cfg_min);
    if (q < 0) q = 0;
    if (q > 255) q = 255;
    return 8'(q);
  endfunction

  // Advance the controller by one accepted beat; queue the result of a tick
  task automatic apply_beat(input in_beat_t b);
    logic [4:0]  hr;
    logic [5:0]  mn;
    logic [6:0]  tc, shown;
    logic [3:0]  h12, hw;
    logic [31:0] held;
    out_beat_t   res;
    hr = (b.clock_hour > HOUR_LAST) ? b.clock_hour - 5'd24 : b.clock_hour;
    mn = (b.clock_minute > MINUTE_LAST) ? MINUTE_LAST : b.clock_minute;
    tc = (b.temp_celsius > TEMP_LAST) ? TEMP_LAST : b.temp_celsius;
    if (b.mode == EV_BUTTON) begin
      held = b.time_ms - press_ms;
      if (b.button_down == KEY_PRESS) begin
        press_ms = b.time_ms;
      end else if (held > 32'(cfg_long)) begin
        if (mode_r == MODE_TIME) begin
          mode_r = MODE_SET_HOUR;
          menu_cnt = '0;
        end
      end else if (mode_r == MODE_TIME || mode_r == MODE_TEMP) begin
        mode_r = MODE_TEMP;
        menu_cnt = '0;
      end else begin
        press_wait = 1'b1;
      end
    end else begin
      res = '0;
      case (mode_r)
        MODE_TIME: begin
          h12 = (hr > 5'd12) ? 4'(hr - 5'd12) : 4'(hr);
          hw = h12;
          bright_r = bright_of(b.light_level);
          edit_hr = 5'(h12);
          // Past the advance minute the next hour is named
          if (mn > HOUR_ADVANCE_MIN) begin
            hw = h12 + 4'd1;
            if (hw > 4'd12) hw = 4'd1;
          end
          if (hw == 4'd0) hw = 4'd12;
          word_hour = hw;
          word_min = 4'(mn / 6'd5);
          word_dots = 3'(mn % 6'd5);
          if (cfg_auto) hue_r = 16'(mn) * HueStep;
        end
        MODE_TEMP: begin
          menu_cnt = menu_cnt + 8'd1;
          if (menu_cnt == cfg_slow) mode_r = MODE_TIME;
        end
        MODE_SET_HOUR: begin
          if (press_wait) begin
            press_wait = 1'b0;
            edit_hr = (edit_hr < HOUR_LAST) ? edit_hr + 5'd1 : 5'd0;
            menu_cnt = '0;
          end
          menu_cnt = menu_cnt + 8'd1;
          if (menu_cnt == cfg_fast) begin
            mode_r = MODE_SET_MIN;
            menu_cnt = '0;
            edit_mn = mn;
          end
        end
        default: begin
          if (press_wait) begin
            press_wait = 1'b0;
            edit_mn = (edit_mn < MINUTE_LAST) ? edit_mn + 6'd1 : 6'd0;
            menu_cnt = '0;
          end
          menu_cnt = menu_cnt + 8'd1;
          // Leaving set-minute commits the edited time
          if (menu_cnt == cfg_fast) begin
            res.clock_write = 1'b1;
            res.write_hour = edit_hr;
            res.write_minute = edit_mn;
            mode_r = MODE_TIME;
          end
        end
      endcase
      if (mode_r != MODE_TIME) begin
        shown = (mode_r == MODE_TEMP) ? tc :
                (mode_r == MODE_SET_HOUR) ? 7'(edit_hr) : 7'(edit_mn);
        res.digit_tens = 4'(shown / 7'd10);
        res.digit_ones = 4'(shown % 7'd10);
      end
      res.display_mode = mode_r;
      res.hour_word = word_hour;
      res.minute_word = word_min;
      res.dot_count = word_dots;
      res.bright_level = bright_r;
      res.hue_value = hue_r;
      expected_q.push_back(res);
    end
  endtask

  task automatic show_beat(input string tag, input out_beat_t b);
    $display("  %s mode %0d hour %0d word %0d dots %0d digits %0d %0d bright %0d hue %0d wr %0b %0d:%0d",
             tag, b.display_mode, b.hour_word, b.minute_word, b.dot_count, b.digit_tens,
             b.digit_ones, b.bright_level, b.hue_value, b.clock_write, b.write_hour,
             b.write_minute);
  endtask

  // Drive the input channel; hold a beat until it is taken
  always @(negedge clk) begin
    if (rst_n && (!in_valid || beat_taken)) begin
      if (beat_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        in_data <= beat_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the output channel, with one long hold-off at the start of the first phase
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  // Check each result beat, then predict from each accepted input beat
  always @(posedge clk) begin : watch
    out_beat_t want;
    string bad;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("result beat with none expected at cycle %0d", cycles);
            show_beat("actual  ", out_data);
          end
        end else begin
          want = expected_q.pop_front();
          bad = "";
          if (out_data.display_mode !== want.display_mode) bad = {bad, " display_mode"};
          if (out_data.hour_word !== want.hour_word) bad = {bad, " hour_word"};
          if (out_data.minute_word !== want.minute_word) bad = {bad, " minute_word"};
          if (out_data.dot_count !== want.dot_count) bad = {bad, " dot_count"};
          if (out_data.digit_tens !== want.digit_tens) bad = {bad, " digit_tens"};
          if (out_data.digit_ones !== want.digit_ones) bad = {bad, " digit_ones"};
          if (out_data.bright_level !== want.bright_level) bad = {bad, " bright_level"};
          if (out_data.hue_value !== want.hue_value) bad = {bad, " hue_value"};
          if (out_data.clock_write !== want.clock_write) bad = {bad, " clock_write"};
          if (out_data.write_hour !== want.write_hour) bad = {bad, " write_hour"};
          if (out_data.write_minute !== want.write_minute) bad = {bad, " write_minute"};
          if (bad != "") begin
            mismatches++;
            if (mismatches <= MaxReports) begin
              $display("result mismatch at cycle %0d:%s", cycles, bad);
              show_beat("expected", want);
              show_beat("actual  ", out_data);
            end
          end
        end
      end
      beat_taken = in_valid && !in_stall;
      if (beat_taken) begin
        accepted++;
        apply_beat(in_data);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_item(input logic ev, input logic down, input logic [31:0] ms,
                           input logic [4:0] hr, input logic [5:0] mn,
                           input logic [6:0] tc, input logic [9:0] lt);
    in_beat_t b;
    b.mode = ev;
    b.button_down = down;
    b.time_ms = ms;
    b.clock_hour = hr;
    b.clock_minute = mn;
    b.temp_celsius = tc;
    b.light_level = lt;
    beat_q.push_back(b);
    pushed++;
  endtask

  task automatic rand_tick();
    push_item(EV_TICK, 1'($urandom_range(1)), $urandom, 5'($urandom_range(31)),
              6'($urandom_range(63)), 7'($urandom_range(127)), 10'($urandom_range(1023)));
  endtask

  task automatic push_edge(input logic down, input logic [31:0] ms);
    push_item(EV_BUTTON, down, ms, 5'($urandom_range(31)), 6'($urandom_range(63)),
              7'($urandom_range(127)), 10'($urandom_range(1023)));
  endtask

  // One random stretch of use: ticks, presses short or long, or stray edges
  task automatic add_session(inout int unsigned counted);
    int unsigned kind, n;
    kind = $urandom_range(99);
    if (kind < 35) begin
      rand_tick();
      counted++;
    end else if (kind < 75) begin
      clock_ms = clock_ms + $urandom_range(1, 5000);
      push_edge(KEY_PRESS, clock_ms);
      if ($urandom_range(99) < 30) rand_tick();
      if (kind < 60) clock_ms = clock_ms + $urandom_range(0, cfg_long);
      else clock_ms = clock_ms + 32'(cfg_long) + $urandom_range(1, 3000);
      push_edge(KEY_RELEASE, clock_ms);
      counted += 2;
    end else if (kind < 90) begin
      n = $urandom_range(1, 30);
      repeat (n) rand_tick();
      counted += n;
    end else begin
      push_edge(1'($urandom_range(1)), $urandom);
    end
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LONG_PRESS: cfg_long = val;
      CFG_TICKS_SLOW: cfg_slow = val[7:0];
      CFG_TICKS_FAST: cfg_fast = val[7:0];
      CFG_AUTO_COLOR: cfg_auto = val[0];
      CFG_MIN_BRIGHT: cfg_min = val[7:0];
      CFG_MAX_BRIGHT: cfg_max = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [15:0] lp, input logic [7:0] slow,
                          input logic [7:0] fast, input logic ac,
                          input logic [7:0] lo, input logic [7:0] hi);
    write_reg(CFG_LONG_PRESS, lp);
    write_reg(CFG_TICKS_SLOW, 16'(slow));
    write_reg(CFG_TICKS_FAST, 16'(fast));
    write_reg(CFG_AUTO_COLOR, 16'(ac));
    write_reg(CFG_MIN_BRIGHT, 16'(lo));
    write_reg(CFG_MAX_BRIGHT, 16'(hi));
  endtask

  // Wait until every beat is taken and every result is in, then let the pipe settle
  task automatic wait_idle();
    do @(negedge clk); while (accepted != pushed || expected_q.size() != 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned counted;
    cfg_long = LONG_PRESS_RST;
    cfg_slow = TICKS_SLOW_RST;
    cfg_fast = TICKS_FAST_RST;
    cfg_auto = 1'b1;
    cfg_min = MIN_BRIGHT_RST;
    cfg_max = MAX_BRIGHT_RST;
    mode_r = MODE_TIME;
    menu_cnt = '0;
    edit_hr = '0;
    edit_mn = '0;
    press_wait = 1'b0;
    press_ms = '0;
    word_hour = '0;
    word_min = '0;
    word_dots = '0;
    hue_r = HUE_RST;
    bright_r = BRIGHT_RST;
    clock_ms = $urandom;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed beats on the reset register values
    @(posedge clk);
    push_item(EV_TICK, 1'b0, 32'd0, 5'd0, 6'd0, 7'd0, 10'd0);
    push_item(EV_TICK, 1'b1, 32'hFFFF_FFFF, 5'd31, 6'd63, 7'd127, 10'd1023);
    push_item(EV_TICK, 1'b0, 32'd0, 5'd23, 6'd40, 7'd50, 10'd500);
    push_item(EV_TICK, 1'b0, 32'd0, 5'd12, 6'd40, 7'd99, 10'd10);
    // Release with no press before it: timed from the reset stamp, short
    push_item(EV_BUTTON, KEY_RELEASE, 32'd100, 5'd0, 6'd0, 7'd0, 10'd0);
    push_item(EV_TICK, 1'b0, 32'd0, 5'd5, 6'd5, 7'd100, 10'd300);
    // Long press across the timestamp wrap, ignored in temperature mode
    push_item(EV_BUTTON, KEY_PRESS, 32'hFFFF_FF00, 5'd0, 6'd0, 7'd0, 10'd0);
    push_item(EV_BUTTON, KEY_RELEASE, 32'h0000_0100, 5'd0, 6'd0, 7'd0, 10'd0);
    // Run the slow timer out; the returning tick keeps hue and words
    repeat (4) push_item(EV_TICK, 1'b0, 32'd0, 5'd7, 6'd17, 7'd42, 10'd800);
    push_item(EV_TICK, 1'b0, 32'd0, 5'd13, 6'd59, 7'd21, 10'd999);
    // Long press into set-hour, then a short press that bumps the hour
    push_item(EV_BUTTON, KEY_PRESS, 32'd2000, 5'd0, 6'd0, 7'd0, 10'd0);
    push_item(EV_BUTTON, KEY_RELEASE, 32'd2501, 5'd0, 6'd0, 7'd0, 10'd0);
    push_item(EV_BUTTON, KEY_PRESS, 32'd3000, 5'd0, 6'd0, 7'd0, 10'd0);
    push_item(EV_BUTTON, KEY_RELEASE, 32'd3500, 5'd0, 6'd0, 7'd0, 10'd0);
    push_item(EV_TICK, 1'b0, 32'd0, 5'd9, 6'd30, 7'd64, 10'd512);
    // Long press inside an edit mode changes nothing
    push_item(EV_BUTTON, KEY_PRESS, 32'd4000, 5'd0, 6'd0, 7'd0, 10'd0);
    push_item(EV_BUTTON, KEY_RELEASE, 32'd4700, 5'd0, 6'd0, 7'd0, 10'd0);
    push_item(EV_TICK, 1'b0, 32'd0, 5'd24, 6'd60, 7'd127, 10'd1);

    for (int unsigned p = 0; p < NumPhases; p++) begin
      wait_idle();
      case (p)
        0: begin
          set_regs(16'd500, 8'd5, 8'd4, 1'b1, 8'd1, 8'd40);
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          set_regs(16'd0, 8'd1, 8'd1, 1'b0, 8'd0, 8'd255);
          src_idle_pct = 71;
          sink_stall_pct = 0;
        end
        2: begin
          set_regs(16'hFFFF, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0);
          src_idle_pct = 0;
          sink_stall_pct = 71;
        end
        3: begin
          set_regs(16'd200, 8'd3, 8'd6, 1'b1, 8'd200, 8'd100);
          src_idle_pct = 9;
          sink_stall_pct = 9;
        end
        4: begin
          set_regs(16'd1000, 8'd2, 8'd3, 1'b0, 8'd0, 8'd0);
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
        5: begin
          set_regs(16'd50, 8'd4, 8'd2, 1'b1, 8'd255, 8'd255);
          src_idle_pct = 71;
          sink_stall_pct = 0;
        end
        6: begin
          set_regs(16'd5000, 8'd7, 8'd5, 1'b1, 8'd10, 8'd200);
          src_idle_pct = 0;
          sink_stall_pct = 71;
        end
        default: begin
          set_regs(LONG_PRESS_RST, TICKS_SLOW_RST, TICKS_FAST_RST, 1'b1,
                   MIN_BRIGHT_RST, MAX_BRIGHT_RST);
          src_idle_pct = 9;
          sink_stall_pct = 9;
        end
      endcase
      @(posedge clk);
      // Hold the output off while beats keep coming so the input backs up
      if (p == 0) hold_left = HoldOffCycles;
      counted = 0;
      while (counted < ItemsPerPhase) add_session(counted);
    end

    wait_idle();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
